FILE: hdl/plar_pkg.sv
// plar_pkg: shared types and register codes for the pid address range lookup
// used by the table memory, the engine and the top level
`timescale 1ns / 1ps

package plar_pkg;

  // one stored range, already in host byte order
  typedef struct packed {
    logic [63:0] range_begin;
    logic [63:0] range_end;
    logic [31:0] pid;
    logic [31:0] name_off;
    logic [31:0] tag_off;
  } entry_t;

  // configuration seen by the engine
  typedef struct packed {
    logic        swap_bytes;
    logic [31:0] blob_size;
  } cfg_t;

  // one result item
  typedef struct packed {
    logic        hit;
    logic [63:0] hit_begin;
    logic [63:0] hit_end;
    logic [31:0] name_at;
    logic        tag_valid;
    logic [31:0] tag_at;
    logic        table_full;
  } result_t;

  // input item kinds
  localparam logic KIND_LOAD   = 1'b0;
  localparam logic KIND_LOOKUP = 1'b1;

  // register index, taken from the word address
  localparam logic REG_SWAP_BYTES = 1'b0;
  localparam logic REG_BLOB_SIZE  = 1'b1;

endpackage

FILE: hdl/plar_chan_if.sv
// plar_chan_if: valid/ready channel interfaces for input items and result items
// standalone, no package dependency
`timescale 1ns / 1ps

interface plar_in_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [63:0] entry_begin;
  logic [63:0] entry_end;
  logic [31:0] process_id;
  logic [31:0] entry_name_offset;
  logic [31:0] entry_tag_offset;
  logic [63:0] lookup_address;

  modport source (
    output valid, kind, entry_begin, entry_end, process_id,
           entry_name_offset, entry_tag_offset, lookup_address,
    input  ready
  );
  modport sink (
    input  valid, kind, entry_begin, entry_end, process_id,
           entry_name_offset, entry_tag_offset, lookup_address,
    output ready
  );
endinterface

interface plar_out_if;
  logic        valid;
  logic        ready;
  logic        hit;
  logic [63:0] hit_begin;
  logic [63:0] hit_end;
  logic [31:0] name_at;
  logic        tag_valid;
  logic [31:0] tag_at;
  logic        table_full;

  modport source (
    output valid, hit, hit_begin, hit_end, name_at, tag_valid, tag_at, table_full,
    input  ready
  );
  modport sink (
    input  valid, hit, hit_begin, hit_end, name_at, tag_valid, tag_at, table_full,
    output ready
  );
endinterface

FILE: hdl/plar_table_mem.sv
// plar_table_mem: range table storage, one write port and one registered read port
// depends on plar_pkg for the entry type
`timescale 1ns / 1ps

module plar_table_mem #(
  parameter int unsigned TABLE_DEPTH = 1024,
  localparam int unsigned IW = $clog2(TABLE_DEPTH)
) (
  input  logic                 clk_i,
  input  logic                 wr_en_i,
  input  logic [IW-1:0]        wr_addr_i,
  input  plar_pkg::entry_t     wr_data_i,
  input  logic                 rd_en_i,
  input  logic [IW-1:0]        rd_addr_i,
  output plar_pkg::entry_t     rd_data_o
);

  plar_pkg::entry_t mem_q [TABLE_DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // read port, registered
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_o <= mem_q[rd_addr_i];
    end
  end

endmodule

FILE: hdl/plar_engine.sv
// plar_engine: load sequencing and binary search over the table memory
// depends on plar_pkg and the channel interfaces; drives plar_table_mem
`timescale 1ns / 1ps

module plar_engine #(
  parameter int unsigned TABLE_DEPTH = 1024,
  localparam int unsigned IW = $clog2(TABLE_DEPTH),
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  plar_pkg::cfg_t    cfg_i,
  plar_in_if.sink           in_i,
  plar_out_if.source        out_o,
  output logic              wr_en_o,
  output logic [IW-1:0]     wr_addr_o,
  output plar_pkg::entry_t  wr_data_o,
  output logic              rd_en_o,
  output logic [IW-1:0]     rd_addr_o,
  input  plar_pkg::entry_t  rd_data_i
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_PROBE,
    S_CMP,
    S_DONE
  } state_e;

  state_e             state_q;
  logic [CW-1:0]      load_ptr_q;
  logic [CW-1:0]      committed_q;
  logic               overflow_q;
  logic [CW-1:0]      lo_q;
  logic [CW-1:0]      hi_q;
  logic [31:0]        key_pid_q;
  logic [63:0]        key_addr_q;
  plar_pkg::result_t  res_q;
  plar_pkg::result_t  out_q;
  logic               out_valid_q;

  logic               accept;
  logic               is_term;
  logic               room;
  logic               full_d;
  logic [CW-1:0]      mid;
  logic [CW-1:0]      mid_inc;
  logic               key_below;
  logic               key_above;
  logic               name_ok;
  logic               tag_ok;

  // handshake and load decode
  assign in_i.ready = (state_q == S_IDLE);
  assign accept     = in_i.valid && in_i.ready;
  assign is_term    = (in_i.kind == plar_pkg::KIND_LOAD) && (in_i.entry_begin == 64'd0) &&
                      (in_i.entry_end == 64'd0) && (in_i.process_id == 32'd0) &&
                      (in_i.entry_name_offset == 32'd0);
  assign room       = (load_ptr_q < CW'(TABLE_DEPTH));
  // drop flag reported with the accepted item
  assign full_d     = overflow_q ||
                      ((in_i.kind == plar_pkg::KIND_LOAD) && !is_term && !room);

  // table write, byte swapped when configured
  assign wr_en_o   = accept && (in_i.kind == plar_pkg::KIND_LOAD) && !is_term && room;
  assign wr_addr_o = load_ptr_q[IW-1:0];
  always_comb begin
    if (cfg_i.swap_bytes) begin
      wr_data_o.range_begin = {<<8{in_i.entry_begin}};
      wr_data_o.range_end   = {<<8{in_i.entry_end}};
      wr_data_o.pid         = {<<8{in_i.process_id}};
      wr_data_o.name_off    = {<<8{in_i.entry_name_offset}};
      wr_data_o.tag_off     = {<<8{in_i.entry_tag_offset}};
    end else begin
      wr_data_o.range_begin = in_i.entry_begin;
      wr_data_o.range_end   = in_i.entry_end;
      wr_data_o.pid         = in_i.process_id;
      wr_data_o.name_off    = in_i.entry_name_offset;
      wr_data_o.tag_off     = in_i.entry_tag_offset;
    end
  end

  // probe address: midpoint of the half-open interval [lo, hi)
  assign mid       = lo_q + ((hi_q - lo_q) >> 1);
  assign mid_inc   = mid + CW'(1);
  assign rd_en_o   = (state_q == S_PROBE);
  assign rd_addr_o = mid[IW-1:0];

  // compare key against the probed entry
  assign key_below = (key_pid_q < rd_data_i.pid) ||
                     ((key_pid_q == rd_data_i.pid) && (key_addr_q < rd_data_i.range_begin));
  assign key_above = (key_pid_q > rd_data_i.pid) ||
                     ((key_pid_q == rd_data_i.pid) && (key_addr_q >= rd_data_i.range_end));
  assign name_ok   = (rd_data_i.name_off != 32'd0) && (rd_data_i.name_off < cfg_i.blob_size);
  assign tag_ok    = (rd_data_i.tag_off != 32'd0) && (rd_data_i.tag_off < cfg_i.blob_size);

  // result channel
  assign out_o.valid      = out_valid_q;
  assign out_o.hit        = out_q.hit;
  assign out_o.hit_begin  = out_q.hit_begin;
  assign out_o.hit_end    = out_q.hit_end;
  assign out_o.name_at    = out_q.name_at;
  assign out_o.tag_valid  = out_q.tag_valid;
  assign out_o.tag_at     = out_q.tag_at;
  assign out_o.table_full = out_q.table_full;

  // sequencer, table counters and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      load_ptr_q  <= '0;
      committed_q <= '0;
      overflow_q  <= 1'b0;
      out_valid_q <= 1'b0;
      lo_q        <= '0;
      hi_q        <= '0;
      key_pid_q   <= '0;
      key_addr_q  <= '0;
      res_q       <= '0;
      out_q       <= '0;
    end else begin
      if (out_valid_q && out_o.ready && (state_q != S_DONE)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            res_q <= {{($bits(plar_pkg::result_t) - 1){1'b0}}, full_d};
            if (in_i.kind == plar_pkg::KIND_LOAD) begin
              state_q <= S_DONE;
              if (is_term) begin
                committed_q <= load_ptr_q;
                load_ptr_q  <= '0;
                overflow_q  <= 1'b0;
              end else begin
                committed_q <= '0;
                if (room) begin
                  load_ptr_q <= load_ptr_q + CW'(1);
                end else begin
                  overflow_q <= 1'b1;
                end
              end
            end else begin
              key_pid_q  <= in_i.process_id;
              key_addr_q <= in_i.lookup_address;
              lo_q       <= '0;
              hi_q       <= committed_q;
              state_q    <= (committed_q != '0) ? S_PROBE : S_DONE;
            end
          end
        end
        S_PROBE: begin
          state_q <= S_CMP;
        end
        S_CMP: begin
          if (key_below) begin
            hi_q    <= mid;
            state_q <= (lo_q < mid) ? S_PROBE : S_DONE;
          end else if (key_above) begin
            lo_q    <= mid_inc;
            state_q <= (mid_inc < hi_q) ? S_PROBE : S_DONE;
          end else begin
            // containing range found: report only with a usable name
            res_q   <= {name_ok,
                        name_ok ? rd_data_i.range_begin : 64'd0,
                        name_ok ? rd_data_i.range_end : 64'd0,
                        name_ok ? rd_data_i.name_off : 32'd0,
                        name_ok && tag_ok,
                        (name_ok && tag_ok) ? rd_data_i.tag_off : 32'd0,
                        res_q.table_full};
            state_q <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid_q || out_o.ready) begin
            out_q       <= res_q;
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: hdl/pid_address_range_lookup_core.sv
// pid_address_range_lookup_core: top level with config registers, engine and table memory
// depends on plar_pkg, plar_chan_if, plar_engine and plar_table_mem
//
//   channel   dir   handshake              carries
//   in_i      in    valid/ready            load entry or lookup key
//   out_o     out   valid/ready            one result item per input item
//   apb       in    psel/penable/pready    swap_bytes (addr 0), blob_size (addr 4)
//
// a load item goes from accept to S_DONE, where its result is written to the output
// register once that register is free, then back to S_IDLE for the next item; a lookup
// runs p probes before S_DONE, p at most clog2(TABLE_DEPTH+1) (11 at 1024);
// each probe is one registered table read and a compare
// reset clears counters and registers only; table contents are undefined until loaded
// one item is in flight at a time; a finished result waits in the output
// register and the next item is accepted while it waits
`timescale 1ns / 1ps

module pid_address_range_lookup_core #(
  parameter int unsigned TABLE_DEPTH = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  plar_in_if.sink     in_i,
  plar_out_if.source  out_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned IW = $clog2(TABLE_DEPTH);

  logic              swap_q;
  logic [31:0]       blob_q;
  logic              reg_wr;
  logic              reg_idx;
  plar_pkg::cfg_t    cfg;
  logic              wr_en;
  logic [IW-1:0]     wr_addr;
  plar_pkg::entry_t  wr_data;
  logic              rd_en;
  logic [IW-1:0]     rd_addr;
  plar_pkg::entry_t  rd_data;

  // register port
  assign pready  = 1'b1;
  assign reg_idx = paddr[2];
  assign reg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      swap_q <= 1'b0;
      blob_q <= '0;
    end else if (reg_wr) begin
      unique case (reg_idx)
        plar_pkg::REG_SWAP_BYTES: swap_q <= pwdata[0];
        plar_pkg::REG_BLOB_SIZE:  blob_q <= pwdata;
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    unique case (reg_idx)
      plar_pkg::REG_SWAP_BYTES: prdata = {31'd0, swap_q};
      plar_pkg::REG_BLOB_SIZE:  prdata = blob_q;
      default:                  prdata = '0;
    endcase
  end

  assign cfg.swap_bytes = swap_q;
  assign cfg.blob_size  = blob_q;

  // search and load sequencer
  plar_engine #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_engine (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg),
    .in_i      (in_i),
    .out_o     (out_o),
    .wr_en_o   (wr_en),
    .wr_addr_o (wr_addr),
    .wr_data_o (wr_data),
    .rd_en_o   (rd_en),
    .rd_addr_o (rd_addr),
    .rd_data_i (rd_data)
  );

  // range table
  plar_table_mem #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

endmodule
